>>> hw/rtl/first_fit_byte_arena_allocator_assert.svh
// Assertion macros used by the arena allocator sequencer.
`ifndef FIRST_FIT_BYTE_ARENA_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_BYTE_ARENA_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define FFBA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ffba: same-cycle check failed");

// Next-cycle implication, disabled while in reset.
`define FFBA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ffba: next-cycle check failed");

`endif

>>> hw/rtl/ffba_pkg.sv
// Constants, types and helper functions of the first-fit arena allocator.
package ffba_pkg;

    localparam int MAX_ARENA = 1024;
    localparam int ADDR_W    = $clog2(MAX_ARENA);
    localparam int CNT_W     = $clog2(MAX_ARENA + 1);
    localparam int RUN_W     = (CNT_W > 8) ? CNT_W : 8;

    localparam int CFG_W    = 11;
    localparam int FUNC_W   = 2;
    localparam int LEN_W    = 8;
    localparam int POS_W    = 10;
    localparam int OUT_W    = 10;
    localparam int STATUS_W = 2;
    localparam int KIND_W   = 2;
    localparam int CELL_W   = 8;
    localparam int PLEN_W   = 7;

    localparam int IN_DATA_W  = ((LEN_W + POS_W + 7) / 8) * 8;
    localparam int OUT_BITS   = 4 * OUT_W + KIND_W;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_FREE  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_INFO  = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_MAP   = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOSPACE  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOTBLOCK = 2'd2;

    localparam logic [KIND_W-1:0] KIND_FREE    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [KIND_W-1:0] KIND_HEADER  = 2'd2;

    localparam logic [CELL_W-1:0] CELL_FREE    = 8'h00;
    localparam logic [CELL_W-1:0] CELL_PAYLOAD = 8'h58;
    localparam logic [CELL_W-1:0] HEADER_FLAG  = 8'h80;
    localparam logic [PLEN_W-1:0] LEN_LIMIT    = 7'h7f;
    localparam logic [OUT_W-1:0]  COUNT_SAT    = 10'd1023;
    localparam logic [CFG_W-1:0]  SIZE_RESET   = 11'd1024;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [OUT_W-1:0]    block_start;
        logic [OUT_W-1:0]    block_count;
        logic [OUT_W-1:0]    used_bytes;
        logic [OUT_W-1:0]    largest_free;
        logic [KIND_W-1:0]   cell_kind;
    } result_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [CELL_W-1:0] wdata;
        logic [ADDR_W-1:0] raddr;
    } ram_req_t;

    function automatic logic [CNT_W-1:0] eff_size(input logic [CFG_W-1:0] a);
        logic [CNT_W-1:0] s;
        if (a == '0) begin
            s = CNT_W'(1);
        end else if (32'(a) > 32'(MAX_ARENA)) begin
            s = CNT_W'(MAX_ARENA);
        end else begin
            s = CNT_W'(a);
        end
        return s;
    endfunction

    function automatic logic [ADDR_W-1:0] clamp_pos(input logic [POS_W-1:0] p,
                                                    input logic [CNT_W-1:0] size);
        logic [ADDR_W-1:0] r;
        if (32'(p) >= 32'(size)) begin
            r = ADDR_W'(size - 1'b1);
        end else begin
            r = ADDR_W'(p);
        end
        return r;
    endfunction

    function automatic logic [OUT_W-1:0] sat_count(input int unsigned v);
        logic [OUT_W-1:0] r;
        if (v > 32'(COUNT_SAT)) begin
            r = COUNT_SAT;
        end else begin
            r = OUT_W'(v);
        end
        return r;
    endfunction

endpackage

>>> hw/rtl/ffba_arena_ram.sv
// Arena cell store: one write port, one registered read port.
module ffba_arena_ram (
    input  logic                          aclk,
    input  ffba_pkg::ram_req_t            req,
    output logic [ffba_pkg::CELL_W-1:0]   rdata
);
    import ffba_pkg::*;

    logic [CELL_W-1:0] mem [MAX_ARENA];

    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr] <= req.wdata;
        end
        rdata <= mem[req.raddr];
    end

endmodule

>>> hw/rtl/ffba_seq.sv
// Sequencer that walks the arena for alloc, free, info and map requests.
`include "first_fit_byte_arena_allocator_assert.svh"

module ffba_seq (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [ffba_pkg::CNT_W-1:0]    size,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [ffba_pkg::FUNC_W-1:0]   in_func,
    input  logic [ffba_pkg::LEN_W-1:0]    in_len,
    input  logic [ffba_pkg::POS_W-1:0]    in_pos,
    output ffba_pkg::ram_req_t            ram_req,
    input  logic [ffba_pkg::CELL_W-1:0]   ram_rdata,
    output logic                          res_valid,
    input  logic                          res_ready,
    output ffba_pkg::result_t             result
);
    import ffba_pkg::*;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_WRITE = 3'd3;
    localparam logic [2:0] S_LOOK  = 3'd4;
    localparam logic [2:0] S_LOOKD = 3'd5;
    localparam logic [2:0] S_ERASE = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    logic [2:0]        state_reg, state_next;
    logic [FUNC_W-1:0] func_reg, func_next;
    logic [PLEN_W-1:0] len_reg, len_next;
    logic [ADDR_W-1:0] pos_reg, pos_next;
    logic [CNT_W-1:0]  issue_reg, issue_next;
    logic              rd_vld_reg, rd_vld_next;
    logic [ADDR_W-1:0] rd_idx_reg, rd_idx_next;
    logic [RUN_W-1:0]  run_reg, run_next;
    logic [RUN_W-1:0]  best_reg, best_next;
    logic [CNT_W-1:0]  blocks_reg, blocks_next;
    logic [CNT_W-1:0]  used_reg, used_next;
    logic [ADDR_W-1:0] ptr_reg, ptr_next;
    logic [ADDR_W-1:0] last_reg, last_next;
    logic [ADDR_W-1:0] start_reg, start_next;
    result_t           res_reg, res_next;

    logic              issuing;
    logic              cell_free;
    logic [RUN_W-1:0]  run_inc;
    logic [RUN_W-1:0]  need;
    logic [RUN_W-1:0]  run_fin;
    logic [31:0]       erase_end;

    assign issuing   = (state_reg == S_SCAN) && (issue_reg < size);
    assign cell_free = (ram_rdata == CELL_FREE);
    assign run_inc   = run_reg + 1'b1;
    assign need      = RUN_W'(len_reg) + 1'b1;
    assign run_fin   = (run_reg > best_reg) ? run_reg : best_reg;
    // free stops at the end of the physical store, not at the arena size
    assign erase_end = 32'(pos_reg) + 32'(ram_rdata[PLEN_W-1:0]);

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign result    = res_reg;

    always_comb begin
        state_next  = state_reg;
        func_next   = func_reg;
        len_next    = len_reg;
        pos_next    = pos_reg;
        issue_next  = issue_reg;
        rd_vld_next = 1'b0;
        rd_idx_next = rd_idx_reg;
        run_next    = run_reg;
        best_next   = best_reg;
        blocks_next = blocks_reg;
        used_next   = used_reg;
        ptr_next    = ptr_reg;
        last_next   = last_reg;
        start_next  = start_reg;
        res_next    = res_reg;

        ram_req.we    = 1'b0;
        ram_req.waddr = ptr_reg;
        ram_req.wdata = CELL_FREE;
        ram_req.raddr = (state_reg == S_SCAN) ? issue_reg[ADDR_W-1:0] : pos_reg;

        unique case (state_reg)
            S_CLEAR: begin
                ram_req.we = 1'b1;
                ptr_next   = ptr_reg + 1'b1;
                if (ptr_reg == ADDR_W'(MAX_ARENA - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_valid) begin
                    func_next   = in_func;
                    len_next    = (in_len > LEN_W'(LEN_LIMIT)) ? LEN_LIMIT
                                                               : in_len[PLEN_W-1:0];
                    pos_next    = clamp_pos(in_pos, size);
                    issue_next  = '0;
                    run_next    = '0;
                    best_next   = '0;
                    blocks_next = '0;
                    used_next   = '0;
                    res_next    = '0;
                    if (in_func == FUNC_ALLOC || in_func == FUNC_INFO) begin
                        state_next = S_SCAN;
                    end else begin
                        state_next = S_LOOK;
                    end
                end
            end
            S_SCAN: begin
                if (issuing) begin
                    issue_next = issue_reg + 1'b1;
                end
                rd_vld_next = issuing;
                rd_idx_next = issue_reg[ADDR_W-1:0];
                if (rd_vld_reg) begin
                    if (func_reg == FUNC_ALLOC) begin
                        if (cell_free) begin
                            run_next = run_inc;
                            if (run_inc == need) begin
                                start_next = ADDR_W'(32'(rd_idx_reg) - 32'(len_reg));
                                ptr_next   = ADDR_W'(32'(rd_idx_reg) - 32'(len_reg));
                                last_next  = rd_idx_reg;
                                state_next = S_WRITE;
                            end
                        end else begin
                            run_next = '0;
                        end
                    end else begin
                        if (cell_free) begin
                            run_next = run_inc;
                        end else begin
                            best_next = run_fin;
                            run_next  = '0;
                            if (ram_rdata == CELL_PAYLOAD) begin
                                used_next = used_reg + 1'b1;
                            end else begin
                                blocks_next = blocks_reg + 1'b1;
                            end
                        end
                    end
                end else if (!issuing) begin
                    // whole arena walked
                    if (func_reg == FUNC_ALLOC) begin
                        res_next.status = ST_NOSPACE;
                    end else begin
                        res_next.block_count  = sat_count(32'(blocks_reg));
                        res_next.used_bytes   = sat_count(32'(used_reg));
                        res_next.largest_free = (run_fin == '0) ? '0
                                              : sat_count(32'(run_fin) - 32'd1);
                    end
                    state_next = S_DONE;
                end
            end
            S_WRITE: begin
                ram_req.we    = 1'b1;
                ram_req.wdata = (ptr_reg == start_reg) ? (HEADER_FLAG | CELL_W'(len_reg))
                                                      : CELL_PAYLOAD;
                ptr_next      = ptr_reg + 1'b1;
                if (ptr_reg == last_reg) begin
                    res_next.status      = ST_OK;
                    res_next.block_start = OUT_W'(start_reg);
                    state_next           = S_DONE;
                end
            end
            S_LOOK: begin
                state_next = S_LOOKD;
            end
            S_LOOKD: begin
                if (func_reg == FUNC_FREE) begin
                    if ((ram_rdata & HEADER_FLAG) != '0) begin
                        ptr_next   = pos_reg;
                        last_next  = (erase_end >= 32'(MAX_ARENA)) ? ADDR_W'(MAX_ARENA - 1)
                                                                   : ADDR_W'(erase_end);
                        state_next = S_ERASE;
                    end else begin
                        res_next.status = ST_NOTBLOCK;
                        state_next      = S_DONE;
                    end
                end else begin
                    if (cell_free) begin
                        res_next.cell_kind = KIND_FREE;
                    end else if (ram_rdata == CELL_PAYLOAD) begin
                        res_next.cell_kind = KIND_PAYLOAD;
                    end else begin
                        res_next.cell_kind = KIND_HEADER;
                    end
                    state_next = S_DONE;
                end
            end
            S_ERASE: begin
                ram_req.we = 1'b1;
                ptr_next   = ptr_reg + 1'b1;
                if (ptr_reg == last_reg) begin
                    res_next.status = ST_OK;
                    state_next      = S_DONE;
                end
            end
            S_DONE: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_CLEAR;
            ptr_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            ptr_reg    <= ptr_next;
            rd_vld_reg <= rd_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        func_reg   <= func_next;
        len_reg    <= len_next;
        pos_reg    <= pos_next;
        issue_reg  <= issue_next;
        rd_idx_reg <= rd_idx_next;
        run_reg    <= run_next;
        best_reg   <= best_next;
        blocks_reg <= blocks_next;
        used_reg   <= used_next;
        last_reg   <= last_next;
        start_reg  <= start_next;
        res_reg    <= res_next;
    end

    `FFBA_ASSERT_NEXT(a_accept_leaves_idle, aclk, aresetn, in_valid && in_ready, state_reg != S_IDLE)
    `FFBA_ASSERT_SAME(a_write_states, aclk, aresetn, ram_req.we, state_reg == S_CLEAR || state_reg == S_WRITE || state_reg == S_ERASE)
    `FFBA_ASSERT_SAME(a_run_below_need, aclk, aresetn, state_reg == S_SCAN && func_reg == FUNC_ALLOC, run_reg < need)
    `FFBA_ASSERT_SAME(a_fill_in_span, aclk, aresetn, state_reg == S_WRITE, ptr_reg >= start_reg && ptr_reg <= last_reg)

endmodule

>>> hw/rtl/first_fit_byte_arena_allocator.sv
// One request at a time: the next is taken only after the result has entered m_axis;
// a full m_axis register holds the sequencer.
// Reset (aresetn low, synchronous) sets arena_size to 1024 and starts a pass that zeroes
// every cell; s_axis_tready stays low until it ends. cfg writes are always taken.
module first_fit_byte_arena_allocator (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [ffba_pkg::CFG_W-1:0]        cfg_wdata,      // arena_size
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [ffba_pkg::IN_DATA_W-1:0]    s_axis_tdata,   // length[7:0], position[17:8]
    input  logic [ffba_pkg::FUNC_W-1:0]       s_axis_tuser,   // func[1:0]
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [ffba_pkg::OUT_DATA_W-1:0]   m_axis_tdata,   // block_start[9:0],
                                                              // block_count[19:10],
                                                              // used_bytes[29:20],
                                                              // largest_free[39:30],
                                                              // cell_kind[41:40]
    output logic [ffba_pkg::STATUS_W-1:0]     m_axis_tuser    // status[1:0]
);
    import ffba_pkg::*;

    logic [CFG_W-1:0]  arena_size_reg;
    logic [CNT_W-1:0]  size;
    ram_req_t          ram_req;
    logic [CELL_W-1:0] ram_rdata;
    logic              res_valid;
    logic              res_ready;
    result_t           res;
    logic              m_valid_reg;
    result_t           m_res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            arena_size_reg <= SIZE_RESET;
        end else if (cfg_we) begin
            arena_size_reg <= cfg_wdata;
        end
    end

    assign size = eff_size(arena_size_reg);

    ffba_arena_ram u_ram (
        .aclk  (aclk),
        .req   (ram_req),
        .rdata (ram_rdata)
    );

    ffba_seq u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .size      (size),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_func   (s_axis_tuser),
        .in_len    (s_axis_tdata[LEN_W-1:0]),
        .in_pos    (s_axis_tdata[LEN_W+POS_W-1:LEN_W]),
        .ram_req   (ram_req),
        .ram_rdata (ram_rdata),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .result    (res)
    );

    // output register
    assign res_ready = !m_valid_reg || m_axis_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            m_res_reg <= res;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = m_res_reg.status;
    assign m_axis_tdata  = OUT_DATA_W'({m_res_reg.cell_kind, m_res_reg.largest_free,
                                        m_res_reg.used_bytes, m_res_reg.block_count,
                                        m_res_reg.block_start});

endmodule

>>> bench/first_fit_byte_arena_allocator_checker.sv
// Arena allocator checker: mirrors the arena, predicts each result and compares it.
`timescale 1ns / 1ps
module first_fit_byte_arena_allocator_checker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [ffba_pkg::CFG_W-1:0]          cfg_wdata,
    input  logic                                s_axis_tvalid,
    input  logic                                s_axis_tready,
    input  logic [ffba_pkg::IN_DATA_W-1:0]      s_axis_tdata,   // length[7:0], position[17:8]
    input  logic [ffba_pkg::FUNC_W-1:0]         s_axis_tuser,   // func[1:0]
    input  logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    input  logic [ffba_pkg::OUT_DATA_W-1:0]     m_axis_tdata,   // block_start, block_count,
                                                                // used_bytes, largest_free,
                                                                // cell_kind
    input  logic [ffba_pkg::STATUS_W-1:0]       m_axis_tuser,   // status[1:0]
    input  logic                                final_check,
    output int                                  failures
);
    import ffba_pkg::*;

    logic [CELL_W-1:0] arena_shadow [MAX_ARENA];
    logic [CFG_W-1:0]  size_setting;
    result_t           awaited_results [$];
    result_t           observed;
    result_t           oldest;
    int unsigned       result_count;
    logic              leftovers_checked;
    int                mismatch_count = 0;

    assign failures = mismatch_count;

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= 40) begin
            $display("MISMATCH at %0t: %s", $time, what);
        end
    endtask

    task automatic check_field(input string name, input logic [OUT_W-1:0] got,
                               input logic [OUT_W-1:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("result %0d %s: got %0d, expected %0d",
                                      result_count, name, got, want));
        end
    endtask

    // 0 behaves as one cell, anything past the store as the whole store
    function automatic int unsigned arena_span();
        int unsigned span;
        span = 32'(size_setting);
        if (span == 0) begin
            span = 1;
        end else if (span > MAX_ARENA) begin
            span = MAX_ARENA;
        end
        return span;
    endfunction

    function automatic logic [OUT_W-1:0] clip_count(input int unsigned n);
        return (n > COUNT_SAT) ? COUNT_SAT : n[OUT_W-1:0];
    endfunction

    // Applies one request to the shadow arena and returns the result it should give.
    function automatic result_t arena_outcome(input logic [FUNC_W-1:0] op,
                                              input logic [LEN_W-1:0]  req_len,
                                              input logic [POS_W-1:0]  req_pos);
        result_t           r;
        int unsigned       span, slot, run, best, headers, payload, want, stop, at;
        logic              found;
        logic [PLEN_W-1:0] plen;
        logic [CELL_W-1:0] c;
        r = '0;
        span = arena_span();
        slot = (32'(req_pos) >= span) ? span - 1 : 32'(req_pos);
        c = arena_shadow[slot];
        case (op)
            FUNC_ALLOC: begin
                plen = (req_len > LEN_LIMIT) ? LEN_LIMIT : req_len[PLEN_W-1:0];
                want = plen + 1;
                run = 0;
                at = 0;
                found = 1'b0;
                for (int i = 0; i < span && !found; i++) begin
                    if (arena_shadow[i] == CELL_FREE) begin
                        run++;
                        if (run == want) begin
                            found = 1'b1;
                            at = i + 1 - want;
                        end
                    end else begin
                        run = 0;
                    end
                end
                if (found) begin
                    arena_shadow[at] = HEADER_FLAG | CELL_W'(plen);
                    for (int i = 1; i <= plen; i++) arena_shadow[at + i] = CELL_PAYLOAD;
                    r.block_start = at[OUT_W-1:0];
                end else begin
                    r.status = ST_NOSPACE;
                end
            end
            FUNC_FREE: begin
                if ((c & HEADER_FLAG) != 0) begin
                    // a block may reach past a shrunk arena; only the store end stops it
                    stop = slot + c[PLEN_W-1:0] + 1;
                    if (stop > MAX_ARENA) stop = MAX_ARENA;
                    for (int i = slot; i < stop; i++) arena_shadow[i] = CELL_FREE;
                end else begin
                    r.status = ST_NOTBLOCK;
                end
            end
            FUNC_INFO: begin
                run = 0;
                best = 0;
                headers = 0;
                payload = 0;
                for (int i = 0; i < span; i++) begin
                    if (arena_shadow[i] == CELL_FREE) begin
                        run++;
                    end else begin
                        if (run > best) best = run;
                        run = 0;
                        if (arena_shadow[i] == CELL_PAYLOAD) payload++;
                        else headers++;
                    end
                end
                if (run > best) best = run;
                r.block_count  = clip_count(headers);
                r.used_bytes   = clip_count(payload);
                r.largest_free = clip_count((best == 0) ? 0 : best - 1);
            end
            default: begin
                if (c == CELL_FREE) r.cell_kind = KIND_FREE;
                else if (c == CELL_PAYLOAD) r.cell_kind = KIND_PAYLOAD;
                else r.cell_kind = KIND_HEADER;
            end
        endcase
        return r;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            foreach (arena_shadow[i]) arena_shadow[i] = CELL_FREE;
            size_setting = SIZE_RESET;
            awaited_results.delete();
            result_count = 0;
            leftovers_checked = 1'b0;
        end else begin
            if (cfg_we) size_setting = cfg_wdata;
            if (s_axis_tvalid && s_axis_tready) begin
                awaited_results.push_back(arena_outcome(s_axis_tuser,
                                                        s_axis_tdata[LEN_W-1:0],
                                                        s_axis_tdata[LEN_W +: POS_W]));
            end
            if (m_axis_tvalid && m_axis_tready) begin
                observed.status       = m_axis_tuser;
                observed.block_start  = m_axis_tdata[0 +: OUT_W];
                observed.block_count  = m_axis_tdata[OUT_W +: OUT_W];
                observed.used_bytes   = m_axis_tdata[2*OUT_W +: OUT_W];
                observed.largest_free = m_axis_tdata[3*OUT_W +: OUT_W];
                observed.cell_kind    = m_axis_tdata[4*OUT_W +: KIND_W];
                if (awaited_results.size() == 0) begin
                    report_mismatch("result arrived with no request outstanding");
                end else begin
                    oldest = awaited_results.pop_front();
                    check_field("status", OUT_W'(observed.status), OUT_W'(oldest.status));
                    check_field("block_start", observed.block_start, oldest.block_start);
                    check_field("block_count", observed.block_count, oldest.block_count);
                    check_field("used_bytes", observed.used_bytes, oldest.used_bytes);
                    check_field("largest_free", observed.largest_free, oldest.largest_free);
                    check_field("cell_kind", OUT_W'(observed.cell_kind),
                                OUT_W'(oldest.cell_kind));
                end
                result_count++;
            end
            if (final_check && !leftovers_checked) begin
                leftovers_checked = 1'b1;
                if (awaited_results.size() != 0) begin
                    report_mismatch($sformatf("%0d results never arrived",
                                              awaited_results.size()));
                end
            end
        end
    end

endmodule

>>> bench/first_fit_byte_arena_allocator_test.sv
// Arena allocator bench top: clock, reset, request and result drivers, and the verdict.
`timescale 1ns / 1ps
module first_fit_byte_arena_allocator_test;
    import ffba_pkg::*;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    localparam int QUIET_LIMIT  = 10000;
    localparam int DRAIN_CYCLES = 1200;
    localparam int PHASES       = 9;

    // random phases: arena size written, number of requests, idling pattern
    int unsigned phase_size  [PHASES] = '{2047, 200, 64, 1, 0, 1024, 300, 16, 500};
    int unsigned phase_items [PHASES] = '{60, 80, 80, 30, 30, 60, 80, 60, 75};
    idle_mode_t  phase_idle  [PHASES] = '{IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH,
                                          IDLE_NONE, IDLE_RECEIVER, IDLE_BOTH, IDLE_SENDER,
                                          IDLE_NONE};

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_we;
    logic [CFG_W-1:0]      cfg_wdata;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;    // length[7:0], position[17:8]
    logic [FUNC_W-1:0]     s_axis_tuser;    // func[1:0]
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;    // block_start[9:0], block_count[19:10],
                                            // used_bytes[29:20], largest_free[39:30],
                                            // cell_kind[41:40]
    logic [STATUS_W-1:0]   m_axis_tuser;    // status[1:0]
    logic                  final_check;
    int                    fail_total;

    int unsigned       gap_pct = 0;
    int unsigned       stall_pct = 0;
    int unsigned       span_now = MAX_ARENA;
    int unsigned       requests_sent = 0;
    int unsigned       results_seen = 0;
    int unsigned       quiet_cycles = 0;
    int unsigned       size_writes = 0;
    int unsigned       blocks_granted = 0;
    int unsigned       allocs_refused = 0;
    int unsigned       bad_frees = 0;
    logic [FUNC_W-1:0] issued_ops [$];
    logic [POS_W-1:0]  live_headers [$];
    logic [FUNC_W-1:0] finished_op;

    first_fit_byte_arena_allocator DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    first_fit_byte_arena_allocator_checker arena_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .final_check   (final_check),
        .failures      (fail_total)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) m_axis_tready <= ($urandom_range(99) >= stall_pct);

    // Tracks which op each result answers, so frees can target real headers.
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready && issued_ops.size() != 0) begin
            finished_op = issued_ops.pop_front();
            results_seen++;
            if (finished_op == FUNC_ALLOC && m_axis_tuser == ST_OK) begin
                blocks_granted++;
                live_headers.push_back(m_axis_tdata[POS_W-1:0]);
            end else if (finished_op == FUNC_ALLOC) begin
                allocs_refused++;
            end else if (finished_op == FUNC_FREE && m_axis_tuser == ST_NOTBLOCK) begin
                bad_frees++;
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic set_idling(input idle_mode_t mode);
        case (mode)
            IDLE_SENDER: begin
                gap_pct = 67;
                stall_pct = 0;
            end
            IDLE_RECEIVER: begin
                gap_pct = 0;
                stall_pct = 67;
            end
            IDLE_BOTH: begin
                gap_pct = 6;
                stall_pct = 6;
            end
            default: begin
                gap_pct = 0;
                stall_pct = 0;
            end
        endcase
    endtask

    // valid stays high from one request to the next unless a gap is drawn
    task automatic send_request(input logic [FUNC_W-1:0] op, input logic [LEN_W-1:0] req_len,
                                input logic [POS_W-1:0] req_pos);
        while ($urandom_range(99) < gap_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {{(IN_DATA_W - LEN_W - POS_W){1'b0}}, req_pos, req_len};
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        issued_ops.push_back(op);
        requests_sent++;
    endtask

    task automatic wait_until_drained();
        s_axis_tvalid <= 1'b0;
        while (results_seen != requests_sent) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_arena_size(input int unsigned value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value[CFG_W-1:0];
        @(posedge aclk);
        cfg_we <= 1'b0;
        span_now = (value == 0) ? 1 : (value > MAX_ARENA) ? MAX_ARENA : value;
        size_writes++;
    endtask

    // Mostly alloc/free traffic on live blocks, with info and map reads mixed in.
    task automatic random_request();
        int unsigned      roll, idx;
        logic [LEN_W-1:0] req_len;
        logic [POS_W-1:0] req_pos;
        roll = $urandom_range(99);
        if (roll < 60) req_len = LEN_W'($urandom_range(15));
        else if (roll < 90) req_len = LEN_W'($urandom_range(127));
        else req_len = LEN_W'($urandom_range(255));
        if ($urandom_range(99) < 70) req_pos = POS_W'($urandom_range(span_now - 1));
        else req_pos = POS_W'($urandom_range(1023));
        roll = $urandom_range(99);
        if (roll < 40) begin
            send_request(FUNC_ALLOC, req_len, req_pos);
        end else if (roll < 70) begin
            if (live_headers.size() != 0 && $urandom_range(99) < 75) begin
                idx = $urandom_range(live_headers.size() - 1);
                req_pos = live_headers[idx];
                live_headers.delete(idx);
            end
            send_request(FUNC_FREE, req_len, req_pos);
        end else if (roll < 82) begin
            send_request(FUNC_INFO, req_len, req_pos);
        end else begin
            send_request(FUNC_MAP, req_len, req_pos);
        end
    endtask

    initial begin
        aresetn       <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_wdata     <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= FUNC_ALLOC;
        final_check   <= 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: full arena, then a two-cell arena
        send_request(FUNC_MAP, 8'd0, 10'd0);
        send_request(FUNC_INFO, 8'd0, 10'd0);
        send_request(FUNC_ALLOC, 8'd0, 10'd0);       // header only
        send_request(FUNC_ALLOC, 8'd255, 10'd0);     // saturates to 127
        send_request(FUNC_ALLOC, 8'd128, 10'd0);
        send_request(FUNC_ALLOC, 8'd5, 10'd1023);
        send_request(FUNC_MAP, 8'd0, 10'd0);
        send_request(FUNC_MAP, 8'd255, 10'd2);
        send_request(FUNC_MAP, 8'd0, 10'd1023);
        send_request(FUNC_FREE, 8'd0, 10'd2);        // payload cell
        send_request(FUNC_FREE, 8'd0, 10'd1023);     // free cell
        send_request(FUNC_FREE, 8'd0, 10'd1);
        send_request(FUNC_ALLOC, 8'd3, 10'd0);       // lands in the freed hole
        send_request(FUNC_ALLOC, 8'd0, 10'd0);
        send_request(FUNC_INFO, 8'd0, 10'd0);
        send_request(FUNC_FREE, 8'd0, 10'd0);
        send_request(FUNC_FREE, 8'd0, 10'd0);        // double free
        send_request(FUNC_ALLOC, 8'd200, 10'd0);
        send_request(FUNC_INFO, 8'd0, 10'd0);
        wait_until_drained();
        write_arena_size(2);
        send_request(FUNC_ALLOC, 8'd0, 10'd0);
        send_request(FUNC_ALLOC, 8'd1, 10'd0);       // no room left
        send_request(FUNC_MAP, 8'd0, 10'd1023);      // clamps onto the header at cell 1
        send_request(FUNC_INFO, 8'd0, 10'd0);
        send_request(FUNC_FREE, 8'd0, 10'd1023);     // block runs past the arena end

        for (int p = 0; p < PHASES; p++) begin
            wait_until_drained();
            write_arena_size(phase_size[p]);
            set_idling(phase_idle[p]);
            repeat (phase_items[p]) random_request();
        end

        wait_until_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        final_check <= 1'b1;
        repeat (2) @(posedge aclk);
        $display("%0d requests over %0d arena size writes (0 to 2047), four idling patterns",
                 requests_sent, size_writes);
        $display("%0d blocks granted, %0d allocs refused, %0d frees of non-header cells",
                 blocks_granted, allocs_refused, bad_frees);
        if (fail_total == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
